### hw/rtl/bba_pkg.sv
// bba_pkg: shared codes and field widths for the buddy block allocator
// no dependencies; used by the interfaces, the top level and the checker
`default_nettype none

package bba_pkg;

  // payload field widths
  localparam int KIND_W  = 2;
  localparam int BYTES_W = 17;
  localparam int NODE_W  = 16;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 16;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESIZE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_MEM    = 2'd2;

endpackage

`default_nettype wire

### hw/rtl/bba_if.sv
// bba_in_if / bba_out_if: request and result channels, valid/ready handshake
// depends on bba_pkg for field widths
`default_nettype none

interface bba_in_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::KIND_W-1:0]    kind;
  logic [bba_pkg::BYTES_W-1:0]   byte_count;
  logic [bba_pkg::NODE_W-1:0]    node_index;
  logic [bba_pkg::BYTES_W-1:0]   new_byte_count;

  modport source (output valid, kind, byte_count, node_index, new_byte_count, input ready);
  modport sink   (input valid, kind, byte_count, node_index, new_byte_count, output ready);
endinterface

interface bba_out_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::NODE_W-1:0]    granted_node;
  logic [bba_pkg::STAT_W-1:0]    status;
  logic                          fits_in_place;
  logic [bba_pkg::CNT_W-1:0]     live_allocations;
  logic [bba_pkg::CNT_W-1:0]     used_granules;

  modport source (output valid, granted_node, status, fits_in_place, live_allocations,
                  used_granules, input ready);
  modport sink   (input valid, granted_node, status, fits_in_place, live_allocations,
                  used_granules, output ready);
endinterface

`default_nettype wire

### hw/rtl/buddy_block_allocator.sv
// buddy_block_allocator: buddy allocator, free lists in three link/tag rams
// depends on bba_pkg, bba_in_if/bba_out_if and bba_ram
// allocate unlinks the head of the lowest fitting list, then splits it down to the order;
//   free merges with free buddies of equal order; resize checks and errors walk no list
// one transaction at a time; the list walk through the rams sets the rate
// reset: clearing pass over every ram address, no input taken
`default_nettype none

module buddy_block_allocator #(
  parameter int NODE_BITS = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  bba_in_if.sink    in_ch,
  bba_out_if.source out_ch
);

  localparam int DEPTH = 1 << NODE_BITS;
  localparam int NH    = NODE_BITS + 1;
  localparam int OW    = $clog2(NODE_BITS + 1);
  localparam int TW    = $clog2(NODE_BITS + 2);

  typedef struct packed {
    logic          bad;
    logic [OW-1:0] ord;
  } ord_t;

  typedef enum logic [9:0] {
    S_CLR       = 10'b0000000001,
    S_IDLE      = 10'b0000000010,
    S_DISPATCH  = 10'b0000000100,
    S_ALLOC_UNL = 10'b0000001000,
    S_SPLIT     = 10'b0000010000,
    S_PUSH_A    = 10'b0000100000,
    S_PUSH_B    = 10'b0001000000,
    S_FREE_RD   = 10'b0010000000,
    S_FREE_CHK  = 10'b0100000000,
    S_DONE      = 10'b1000000000
  } state_t;

  // order of a byte count: bit length of ceil(bytes/8)-1
  function automatic ord_t size_order(input logic [bba_pkg::BYTES_W-1:0] bytes);
    logic [13:0] units;
    logic [12:0] u;
    logic [4:0]  bits;
    ord_t        r;
    units = 14'((17'(bytes[15:0]) + 17'd7) >> 3);
    u     = (units != 14'd0) ? 13'(units - 14'd1) : 13'd0;
    bits  = 5'd0;
    for (int i = 0; i < 13; i++) begin
      if (u[i]) begin
        bits = 5'(i + 1);
      end
    end
    r.bad = bytes[16] || (32'(bits) > NODE_BITS);
    r.ord = OW'(bits);
    return r;
  endfunction

  state_t                          state_r;
  logic [NODE_BITS-1:0]            clr_r;
  logic [NODE_BITS-1:0]            head_r [NH];
  logic [bba_pkg::CNT_W-1:0]       live_r;
  logic [bba_pkg::CNT_W-1:0]       used_r;
  logic [bba_pkg::KIND_W-1:0]      kind_r;
  ord_t                            oa_r;
  ord_t                            ob_r;
  logic [NODE_BITS-1:0]            node_r;
  logic [NODE_BITS-1:0]            pn_r;
  logic [NODE_BITS-1:0]            h_r;
  logic [NODE_BITS-1:0]            buddy_r;
  logic [OW-1:0]                   k_r;
  logic [OW-1:0]                   ord_r;
  logic [NODE_BITS-1:0]            res_granted_r;
  logic [bba_pkg::STAT_W-1:0]      res_status_r;
  logic                            res_fits_r;
  logic                            out_valid_r;
  logic [bba_pkg::NODE_W-1:0]      out_granted_r;
  logic [bba_pkg::STAT_W-1:0]      out_status_r;
  logic                            out_fits_r;
  logic [bba_pkg::CNT_W-1:0]       out_live_r;
  logic [bba_pkg::CNT_W-1:0]       out_used_r;

  // ram ports
  logic                 tag_we, prev_we, next_we;
  logic [NODE_BITS-1:0] tag_wa, prev_wa, next_wa;
  logic [TW-1:0]        tag_wd, tag_q;
  logic [NODE_BITS-1:0] prev_wd, next_wd, prev_q, next_q;
  logic [NODE_BITS-1:0] rd_addr;

  // combinational helpers
  logic                 alloc_found;
  logic [OW-1:0]        alloc_k;
  logic [TW-1:0]        clr_tag;
  logic [NODE_BITS-1:0] unl_node;
  logic [NODE_BITS-1:0] cur_bit;
  logic [NODE_BITS-1:0] buddy;
  logic                 tag_match;
  logic                 at_top;

  bba_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_tag_ram (
    .clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd), .raddr(rd_addr), .rdata(tag_q)
  );
  bba_ram #(.WIDTH(NODE_BITS), .DEPTH(DEPTH)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd), .raddr(rd_addr),
    .rdata(prev_q)
  );
  bba_ram #(.WIDTH(NODE_BITS), .DEPTH(DEPTH)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd), .raddr(rd_addr),
    .rdata(next_q)
  );

  // lowest non-empty order at or above the request
  always_comb begin
    alloc_found = 1'b0;
    alloc_k     = '0;
    for (int i = NH - 1; i >= 0; i--) begin
      if (head_r[i] != '0 && OW'(i) >= oa_r.ord) begin
        alloc_found = 1'b1;
        alloc_k     = OW'(i);
      end
    end
  end

  // tag value written by the clearing pass: order plus one at power-of-two nodes
  always_comb begin
    clr_tag = '0;
    for (int i = 0; i < NODE_BITS; i++) begin
      if (clr_r == (NODE_BITS'(1) << i)) begin
        clr_tag = TW'(i + 1);
      end
    end
  end

  assign cur_bit   = NODE_BITS'(1) << k_r;
  assign buddy     = node_r ^ cur_bit;
  assign at_top    = (32'(k_r) == NODE_BITS);
  assign tag_match = (tag_q == TW'(k_r) + TW'(1));
  assign unl_node  = (state_r == S_ALLOC_UNL) ? node_r : buddy_r;

  // ram write and read control
  always_comb begin
    tag_we  = 1'b0;
    tag_wa  = '0;
    tag_wd  = '0;
    prev_we = 1'b0;
    prev_wa = '0;
    prev_wd = '0;
    next_we = 1'b0;
    next_wa = '0;
    next_wd = '0;
    rd_addr = '0;
    unique case (state_r)
      S_CLR: begin
        tag_we  = 1'b1;
        tag_wa  = clr_r;
        tag_wd  = clr_tag;
        prev_we = 1'b1;
        prev_wa = clr_r;
        next_we = 1'b1;
        next_wa = clr_r;
      end
      S_DISPATCH: begin
        rd_addr = head_r[alloc_k];
      end
      S_ALLOC_UNL, S_FREE_CHK: begin
        // unlink: next[p] = n, prev[n] = p, tag cleared
        if (state_r == S_ALLOC_UNL || tag_match) begin
          next_we = (prev_q != '0);
          next_wa = prev_q;
          next_wd = next_q;
          prev_we = (next_q != '0);
          prev_wa = next_q;
          prev_wd = prev_q;
          tag_we  = 1'b1;
          tag_wa  = unl_node;
        end
      end
      S_PUSH_A: begin
        prev_we = 1'b1;
        prev_wa = pn_r;
        next_we = 1'b1;
        next_wa = pn_r;
        next_wd = head_r[k_r];
        tag_we  = 1'b1;
        tag_wa  = pn_r;
        tag_wd  = TW'(k_r) + TW'(1);
      end
      S_PUSH_B: begin
        prev_we = (h_r != '0);
        prev_wa = h_r;
        prev_wd = pn_r;
      end
      S_FREE_RD: begin
        rd_addr = buddy;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      live_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NH; i++) begin
        head_r[i] <= (i < NODE_BITS) ? (NODE_BITS'(1) << i) : '0;
      end
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + NODE_BITS'(1);
          if (clr_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            kind_r        <= in_ch.kind;
            oa_r          <= size_order(in_ch.byte_count);
            ob_r          <= size_order(in_ch.new_byte_count);
            node_r        <= NODE_BITS'(in_ch.node_index);
            res_granted_r <= '0;
            res_status_r  <= bba_pkg::ST_OK;
            res_fits_r    <= 1'b0;
            state_r       <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state_r <= S_DONE;
          case (kind_r)
            bba_pkg::KIND_ALLOC: begin
              if (oa_r.bad) begin
                res_status_r <= bba_pkg::ST_TOO_LARGE;
              end else if (!alloc_found) begin
                res_status_r <= bba_pkg::ST_NO_MEM;
              end else begin
                k_r     <= alloc_k;
                ord_r   <= oa_r.ord;
                node_r  <= head_r[alloc_k];
                state_r <= S_ALLOC_UNL;
              end
            end
            bba_pkg::KIND_FREE: begin
              if (oa_r.bad) begin
                res_status_r <= bba_pkg::ST_TOO_LARGE;
              end else if (node_r != '0) begin
                live_r  <= live_r - 16'd1;
                used_r  <= used_r - 16'(32'd1 << oa_r.ord);
                k_r     <= oa_r.ord;
                state_r <= S_FREE_RD;
              end
            end
            bba_pkg::KIND_RESIZE: begin
              if (oa_r.bad || ob_r.bad) begin
                res_status_r <= bba_pkg::ST_TOO_LARGE;
              end else begin
                res_fits_r <= (oa_r.ord >= ob_r.ord);
              end
            end
            default: begin
            end
          endcase
        end
        S_ALLOC_UNL: begin
          if (prev_q == '0) begin
            head_r[k_r] <= next_q;
          end
          live_r        <= live_r + 16'd1;
          used_r        <= used_r + 16'(32'd1 << ord_r);
          res_granted_r <= node_r;
          state_r       <= S_SPLIT;
        end
        S_SPLIT: begin
          // return the upper half to the next lower order
          if (k_r == ord_r) begin
            state_r <= S_DONE;
          end else begin
            k_r     <= k_r - OW'(1);
            pn_r    <= node_r + (NODE_BITS'(1) << (k_r - OW'(1)));
            state_r <= S_PUSH_A;
          end
        end
        S_PUSH_A: begin
          head_r[k_r] <= pn_r;
          h_r         <= head_r[k_r];
          state_r     <= S_PUSH_B;
        end
        S_PUSH_B: begin
          state_r <= (kind_r == bba_pkg::KIND_ALLOC) ? S_SPLIT : S_DONE;
        end
        S_FREE_RD: begin
          if (at_top || buddy == '0) begin
            pn_r    <= node_r;
            state_r <= S_PUSH_A;
          end else begin
            buddy_r <= buddy;
            state_r <= S_FREE_CHK;
          end
        end
        S_FREE_CHK: begin
          // merge with a free buddy of equal order
          if (tag_match) begin
            if (prev_q == '0) begin
              head_r[k_r] <= next_q;
            end
            node_r  <= node_r & ~cur_bit;
            k_r     <= k_r + OW'(1);
            state_r <= S_FREE_RD;
          end else begin
            pn_r    <= node_r;
            state_r <= S_PUSH_A;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r   <= 1'b1;
            out_granted_r <= bba_pkg::NODE_W'(res_granted_r);
            out_status_r  <= res_status_r;
            out_fits_r    <= res_fits_r;
            out_live_r    <= live_r;
            out_used_r    <= used_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // channel outputs
  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.granted_node     = out_granted_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.fits_in_place    = out_fits_r;
  assign out_ch.live_allocations = out_live_r;
  assign out_ch.used_granules    = out_used_r;

endmodule

`default_nettype wire

### hw/rtl/bba_ram.sv
// bba_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/bba_checker.sv
// bba_checker: port-level assertions for buddy_block_allocator, bound to the top
// depends on bba_pkg for status codes
`default_nettype none

module bba_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [bba_pkg::NODE_W-1:0]    granted_node,
  input wire logic [bba_pkg::STAT_W-1:0]    status,
  input wire logic                          fits_in_place
);

  // a stalled result transaction stays valid and holds its granted node and status
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(granted_node) && $stable(status))
    else $error("result changed while stalled");

  // a failed request never hands out a block
  a_err_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != bba_pkg::ST_OK |-> granted_node == '0)
    else $error("block granted with error status");

  // fit flag only on a clean resize check, never alongside a grant
  a_fits_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fits_in_place |-> status == bba_pkg::ST_OK && granted_node == '0)
    else $error("fit flag with grant or error");

  // status is always one of the defined codes
  a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status <= bba_pkg::ST_NO_MEM)
    else $error("undefined status code");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .granted_node     (out_ch.granted_node),
  .status           (out_ch.status),
  .fits_in_place    (out_ch.fits_in_place)
);

`default_nettype wire

### tb/sv/tb_buddy_block_allocator.sv
// tb_buddy_block_allocator: self-checking testbench for the buddy allocator
// depends on bba_pkg, bba_in_if/bba_out_if and buddy_block_allocator
// a predictor in a scoreboard class mirrors the free lists and checks each result
`timescale 1ns / 1ps

typedef struct packed {
  logic [bba_pkg::KIND_W-1:0]  kind;
  logic [bba_pkg::BYTES_W-1:0] byte_count;
  logic [bba_pkg::NODE_W-1:0]  node_index;
  logic [bba_pkg::BYTES_W-1:0] new_byte_count;
} alloc_req_t;

typedef struct packed {
  logic [bba_pkg::NODE_W-1:0] granted_node;
  logic [bba_pkg::STAT_W-1:0] status;
  logic                       fits_in_place;
  logic [bba_pkg::CNT_W-1:0]  live_allocations;
  logic [bba_pkg::CNT_W-1:0]  used_granules;
} alloc_rsp_t;

class alloc_scoreboard;
  localparam int ORDERS = 16;
  localparam int NODES  = 1 << ORDERS;

  bit [4:0]        free_tag[NODES];
  bit [15:0]       back_ptr[NODES];
  bit [15:0]       fwd_ptr[NODES];
  bit [15:0]       list_head[ORDERS+1];
  bit [15:0]       block_count;
  bit [15:0]       granule_sum;
  alloc_rsp_t      awaited_rsp[$];
  bit              failed;

  function new();
    foreach (free_tag[i]) begin
      free_tag[i] = 0;
      back_ptr[i] = 0;
      fwd_ptr[i]  = 0;
    end
    foreach (list_head[i]) list_head[i] = 0;
    for (int i = 0; i < ORDERS; i++) add_to_list(1 << i, i);
    block_count = 0;
    granule_sum = 0;
    failed      = 0;
  endfunction

  // bit length of ceil(bytes/8)-1, or -1 when too large
  function int size_to_order(bit [16:0] bytes);
    int units;
    int bits;
    if (bytes > 17'h0FFFF) return -1;
    units = (int'(bytes) + 7) / 8;
    units = (units != 0) ? units - 1 : 0;
    bits  = 0;
    while (units != 0) begin
      bits++;
      units = units >> 1;
    end
    if (bits > ORDERS) return -1;
    return bits;
  endfunction

  function void add_to_list(int node, int ord);
    bit [15:0] h;
    h = list_head[ord];
    back_ptr[node[15:0]] = 0;
    fwd_ptr[node[15:0]]  = h;
    if (h != 0) back_ptr[h] = node[15:0];
    list_head[ord] = node[15:0];
    free_tag[node[15:0]] = 5'(ord + 1);
  endfunction

  function void drop_from_list(int node, int ord);
    bit [15:0] p;
    bit [15:0] n;
    p = back_ptr[node[15:0]];
    n = fwd_ptr[node[15:0]];
    if (p != 0) fwd_ptr[p] = n;
    else list_head[ord] = n;
    if (n != 0) back_ptr[n] = p;
    free_tag[node[15:0]] = 0;
  endfunction

  // record an accepted request and return its predicted result
  function alloc_rsp_t note_request(alloc_req_t req);
    alloc_rsp_t rsp;
    int ord;
    int k;
    int node;
    int ob;
    int buddy;
    rsp = '0;
    ord = size_to_order(req.byte_count);
    if (req.kind == bba_pkg::KIND_ALLOC) begin
      if (ord < 0) rsp.status = bba_pkg::ST_TOO_LARGE;
      else begin
        k = ord;
        while (k <= ORDERS && list_head[k] == 0) k++;
        if (k > ORDERS) rsp.status = bba_pkg::ST_NO_MEM;
        else begin
          node = list_head[k];
          drop_from_list(node, k);
          // split, returning upper halves
          while (k != ord) begin
            k--;
            add_to_list(node + (1 << k), k);
          end
          rsp.granted_node = node[15:0];
          block_count++;
          granule_sum += 16'(1 << ord);
        end
      end
    end else if (req.kind == bba_pkg::KIND_FREE) begin
      node = req.node_index;
      if (ord < 0) rsp.status = bba_pkg::ST_TOO_LARGE;
      else if (node != 0) begin
        block_count--;
        granule_sum -= 16'(1 << ord);
        // merge with free buddies of equal order
        while (ord < ORDERS) begin
          buddy = (node ^ (1 << ord)) & (NODES - 1);
          if (buddy == 0 || free_tag[buddy] != 5'(ord + 1)) break;
          drop_from_list(buddy, ord);
          node = node & ~(1 << ord);
          ord++;
        end
        add_to_list(node, ord);
      end
    end else if (req.kind == bba_pkg::KIND_RESIZE) begin
      ob = size_to_order(req.new_byte_count);
      if (ord < 0 || ob < 0) rsp.status = bba_pkg::ST_TOO_LARGE;
      else rsp.fits_in_place = (ord >= ob);
    end
    rsp.live_allocations = block_count;
    rsp.used_granules    = granule_sum;
    awaited_rsp.push_back(rsp);
    return rsp;
  endfunction

  function void compare_field(string name, longint unsigned exp_v, logic [16:0] act_v);
    if (act_v !== 17'(exp_v)) begin
      failed = 1;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  function void check_result(alloc_rsp_t got);
    alloc_rsp_t exp;
    if (awaited_rsp.size() == 0) begin
      failed = 1;
      $display("%0t: unexpected result, expected none, actual %p", $time, got);
      return;
    end
    exp = awaited_rsp.pop_front();
    compare_field("granted_node", exp.granted_node, got.granted_node);
    compare_field("status", exp.status, got.status);
    compare_field("fits_in_place", exp.fits_in_place, got.fits_in_place);
    compare_field("live_allocations", exp.live_allocations, got.live_allocations);
    compare_field("used_granules", exp.used_granules, got.used_granules);
  endfunction
endclass

module tb_buddy_block_allocator;
  localparam logic [bba_pkg::KIND_W-1:0] KIND_NOP = 2'd3;

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;

  alloc_scoreboard sb;
  bit [15:0]       live_node[$];
  int              live_ord[$];

  bba_in_if  in_if();
  bba_out_if out_if();

  buddy_block_allocator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #3ms;
    $display("FAIL buddy_block_allocator");
    $finish;
  end

  // result side: check each transaction, stall at random
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result({out_if.granted_node, out_if.status, out_if.fits_in_place,
                       out_if.live_allocations, out_if.used_granules});
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // drive one request and wait until it is accepted
  task automatic send(logic [bba_pkg::KIND_W-1:0] kind, logic [bba_pkg::BYTES_W-1:0] bytes,
                      logic [bba_pkg::NODE_W-1:0] node,
                      logic [bba_pkg::BYTES_W-1:0] new_bytes);
    alloc_rsp_t rsp;
    if ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.kind           <= kind;
    in_if.byte_count     <= bytes;
    in_if.node_index     <= node;
    in_if.new_byte_count <= new_bytes;
    do @(posedge clk); while (!in_if.ready);
    rsp = sb.note_request({kind, bytes, node, new_bytes});
    if (kind == bba_pkg::KIND_ALLOC && rsp.status == bba_pkg::ST_OK) begin
      live_node.push_back(rsp.granted_node);
      live_ord.push_back(sb.size_to_order(bytes));
    end
  endtask

  // random byte count that maps to the given order
  function automatic logic [bba_pkg::BYTES_W-1:0] bytes_for(int ord);
    int lo;
    int hi;
    lo = (ord == 0) ? 0 : (8 << (ord - 1)) + 1;
    hi = (8 << ord);
    if (hi > 65535) hi = 65535;
    return bba_pkg::BYTES_W'($urandom_range(hi, lo));
  endfunction

  // free a tracked live block, sized anywhere within its order
  task automatic free_live();
    int idx;
    bit [15:0] node;
    int ord;
    idx  = $urandom_range(live_node.size() - 1);
    node = live_node[idx];
    ord  = live_ord[idx];
    live_node.delete(idx);
    live_ord.delete(idx);
    send(bba_pkg::KIND_FREE, bytes_for(ord), node, bba_pkg::BYTES_W'($urandom));
  endtask

  task automatic random_request();
    int r;
    int ord;
    r = $urandom_range(99);
    if (r < 48 && live_node.size() < 200) begin
      ord = ($urandom_range(9) == 0) ? $urandom_range(13, 7) : $urandom_range(5, 0);
      send(bba_pkg::KIND_ALLOC, bytes_for(ord), bba_pkg::NODE_W'($urandom),
           bba_pkg::BYTES_W'($urandom));
    end else if (r < 88 && live_node.size() > 0) begin
      free_live();
    end else if (r < 92) begin
      send(bba_pkg::KIND_RESIZE, bba_pkg::BYTES_W'($urandom_range(70000)),
           bba_pkg::NODE_W'($urandom), bba_pkg::BYTES_W'($urandom_range(70000)));
    end else if (r < 95) begin
      send(bba_pkg::KIND_ALLOC, bba_pkg::BYTES_W'($urandom), bba_pkg::NODE_W'($urandom),
           bba_pkg::BYTES_W'($urandom));
    end else if (r < 98) begin
      send(KIND_NOP, bba_pkg::BYTES_W'($urandom), bba_pkg::NODE_W'($urandom),
           bba_pkg::BYTES_W'($urandom));
    end else begin
      // misuse: free of an arbitrary node and size
      send(bba_pkg::KIND_FREE, bba_pkg::BYTES_W'($urandom_range(65535)),
           bba_pkg::NODE_W'($urandom), bba_pkg::BYTES_W'($urandom));
    end
  endtask

  initial begin
    sb                   = new();
    idle_pct             = 0;
    stall_pct            = 0;
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.kind           = bba_pkg::KIND_ALLOC;
    in_if.byte_count     = '0;
    in_if.node_index     = '0;
    in_if.new_byte_count = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: size edges, errors, every kind
    send(bba_pkg::KIND_ALLOC, 17'd0, 16'd0, 17'd0);
    send(bba_pkg::KIND_ALLOC, 17'd8, 16'hFFFF, 17'h1FFFF);
    send(bba_pkg::KIND_ALLOC, 17'd9, 16'd0, 17'd0);
    send(bba_pkg::KIND_ALLOC, 17'd65536, 16'd0, 17'd0);
    send(bba_pkg::KIND_ALLOC, 17'h1FFFF, 16'd0, 17'd0);
    send(bba_pkg::KIND_FREE, 17'd0, 16'd0, 17'd0);
    send(bba_pkg::KIND_FREE, 17'd70000, 16'd3, 17'd0);
    send(bba_pkg::KIND_RESIZE, 17'd64, 16'd0, 17'd65);
    send(bba_pkg::KIND_RESIZE, 17'd65, 16'd0, 17'd64);
    send(bba_pkg::KIND_RESIZE, 17'd65535, 16'd0, 17'd65536);
    send(bba_pkg::KIND_RESIZE, 17'h1FFFF, 16'd0, 17'd0);
    send(KIND_NOP, 17'h1FFFF, 16'hFFFF, 17'h1FFFF);
    // use up every block large enough for the largest requests, then hand them all back
    repeat (8) send(bba_pkg::KIND_ALLOC, 17'd65535, 16'd0, 17'd0);
    while (live_node.size() > 0) free_live();

    // random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 30 : 0;
      stall_pct = (ph == 2) ? 50 : (ph == 3) ? 30 : 0;
      repeat (400) random_request();
    end

    in_if.valid <= 1'b0;
    while (sb.awaited_rsp.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (!sb.failed && sb.awaited_rsp.size() == 0) begin
      $display("PASS buddy_block_allocator");
    end else begin
      $display("FAIL buddy_block_allocator");
    end
    $finish;
  end
endmodule
